@@ rtl/core/iac_pkg.sv @@
// shared types, constants and a helper function for the attitude filter
`timescale 1ns / 1ps
package iac_pkg;

	localparam int SAMPLE_BITS  = 16;
	localparam int CORDIC_STEPS = 16;
	localparam int TABLE_LEN    = 32;
	localparam int STEP_W       = 5;
	localparam int CFG_W        = 17;
	localparam int ANG_W        = 32;
	localparam int MUL_W        = 33;
	localparam int PROD_W       = 2 * MUL_W;
	localparam int MAG_W        = (SAMPLE_BITS + 2 > CFG_W) ? SAMPLE_BITS + 2 : CFG_W;
	localparam int SQ_W         = 2 * SAMPLE_BITS + 16;
	localparam int SQRT_TOP     = 2 * SAMPLE_BITS + 14;
	localparam int SQRT_STEPS   = SAMPLE_BITS + 8;
	localparam int RAW_W        = SAMPLE_BITS + 9;
	localparam int CW           = RAW_W + 19;
	localparam int Q16_ONE      = 65536;

	localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(32768);
	localparam logic signed [ANG_W-1:0]  Z_90     = ANG_W'(90 * Q16_ONE);

	localparam logic signed [ANG_W-1:0] ATAN_TAB [TABLE_LEN] = '{
		32'sd2949120, 32'sd1740967, 32'sd919879, 32'sd466945,
		32'sd234379, 32'sd117304, 32'sd58666, 32'sd29335,
		32'sd14668, 32'sd7334, 32'sd3667, 32'sd1833,
		32'sd917, 32'sd458, 32'sd229, 32'sd115,
		32'sd57, 32'sd29, 32'sd14, 32'sd7,
		32'sd4, 32'sd2, 32'sd1, 32'sd0,
		32'sd0, 32'sd0, 32'sd0, 32'sd0,
		32'sd0, 32'sd0, 32'sd0, 32'sd0
	};

	localparam logic [1:0] REG_GAIN   = 2'd0;
	localparam logic [1:0] REG_MAG_LO = 2'd1;
	localparam logic [1:0] REG_MAG_HI = 2'd2;
	localparam logic [1:0] REG_BLEND  = 2'd3;

	localparam logic [1:0] AXIS_PITCH = 2'd0;
	localparam logic [1:0] AXIS_ROLL  = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;

	typedef struct packed {
		logic signed [SAMPLE_BITS-1:0] gyro_x;
		logic signed [SAMPLE_BITS-1:0] gyro_y;
		logic signed [SAMPLE_BITS-1:0] gyro_z;
		logic signed [SAMPLE_BITS-1:0] accel_x;
		logic signed [SAMPLE_BITS-1:0] accel_y;
		logic signed [SAMPLE_BITS-1:0] accel_z;
	} in_t;

	typedef struct packed {
		logic signed [ANG_W-1:0] pitch_out;
		logic signed [ANG_W-1:0] roll_out;
		logic signed [ANG_W-1:0] yaw_out;
		logic                    corrected;
	} out_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_LOAD, OP_GMUL, OP_GADD, OP_SQX, OP_SQZ, OP_SQI, OP_SQS,
		OP_CINIT, OP_CSTEP, OP_BMA, OP_BMB, OP_BSUM, OP_OUT
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [1:0]        axis;
		logic [STEP_W-1:0] step;
	} cmd_t;

	typedef struct packed {
		logic corr;
	} stat_t;

	function automatic logic signed [ANG_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
		logic [PROD_W-ANG_W:0] top;
		top = v[PROD_W-1:ANG_W-1];
		if (&top || ~|top) begin
			return v[ANG_W-1:0];
		end
		return v[PROD_W-1] ? {1'b1, {(ANG_W-1){1'b0}}} : {1'b0, {(ANG_W-1){1'b1}}};
	endfunction

endpackage

@@ rtl/core/imu_complementary_attitude.sv @@
// top level: register port, sequencer and datapath of the attitude filter
// usage:
//  - input channel in_valid/in_ready/in_data carries one six-axis sample per request
//  - output channel out_valid/out_ready/out_data returns the updated pitch, roll
//    and yaw angles (Q16.16 degrees) and the corrected flag, one per request
//  - in_ready is high only while the sequencer is idle; one request at a time
//  - an accepted request runs the gyro pass and the magnitude check, and with
//    correction the isqrt and then a cordic and blend pass for each angle
//  - the next request can be taken at the earliest in the same cycle as
//    out_valid rises
//  - the pace is set by the shared isqrt unit (one result bit a cycle) and
//    the shared cordic unit (one rotation a cycle, three angles in turn)
//  - a new request is taken while a result waits in the output register;
//    if the receiver still stalls when the next result is ready, the sequencer
//    holds it and takes no further request
//  - reset clears the angles and the output valid flag and loads the register
//    defaults; configuration writes through the apb port take effect at once
`timescale 1ns / 1ps
module imu_complementary_attitude
	import iac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  in_t         in_data,
	output logic        out_valid,
	input  logic        out_ready,
	output out_t        out_data,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [31:0]      gyro_gain_q;
	logic [CFG_W-1:0] magnitude_low_q, magnitude_high_q, blend_weight_q;
	logic             wr_en;
	cmd_t             cmd;
	stat_t            stat;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gyro_gain_q      <= 32'd2621440;
			magnitude_low_q  <= CFG_W'(8192);
			magnitude_high_q <= CFG_W'(32768);
			blend_weight_q   <= CFG_W'(64225);
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_GAIN:   gyro_gain_q      <= pwdata;
				REG_MAG_LO: magnitude_low_q  <= pwdata[CFG_W-1:0];
				REG_MAG_HI: magnitude_high_q <= pwdata[CFG_W-1:0];
				REG_BLEND:  blend_weight_q   <= pwdata[CFG_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_GAIN:   prdata = gyro_gain_q;
			REG_MAG_LO: prdata = 32'(magnitude_low_q);
			REG_MAG_HI: prdata = 32'(magnitude_high_q);
			REG_BLEND:  prdata = 32'(blend_weight_q);
			default:    prdata = '0;
		endcase
	end

	iac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	iac_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_data        (in_data),
		.cmd            (cmd),
		.gyro_gain      (gyro_gain_q),
		.magnitude_low  (magnitude_low_q),
		.magnitude_high (magnitude_high_q),
		.blend_weight   (blend_weight_q),
		.stat           (stat),
		.out_data       (out_data)
	);

endmodule

@@ rtl/core/iac_ctrl.sv @@
// sequencing state machine for the attitude filter
`timescale 1ns / 1ps
module iac_ctrl
	import iac_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	output logic  out_valid,
	input  logic  out_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	typedef enum logic [13:0] {
		S_IDLE   = 14'b00000000000001,
		S_GMUL   = 14'b00000000000010,
		S_GADD   = 14'b00000000000100,
		S_CHECK  = 14'b00000000001000,
		S_SQX    = 14'b00000000010000,
		S_SQZ    = 14'b00000000100000,
		S_SQI    = 14'b00000001000000,
		S_SQS    = 14'b00000010000000,
		S_CINIT  = 14'b00000100000000,
		S_CSTEP  = 14'b00001000000000,
		S_BMA    = 14'b00010000000000,
		S_BMB    = 14'b00100000000000,
		S_BSUM   = 14'b01000000000000,
		S_DONE   = 14'b10000000000000
	} state_t;

	state_t            state_q, state_d;
	logic [1:0]        axis_q, axis_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q, out_valid_d;
	op_t               op;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign cmd       = '{op: op, axis: axis_q, step: step_q};

	always_comb begin
		state_d     = state_q;
		axis_d      = axis_q;
		step_d      = step_q;
		out_valid_d = out_valid_q && !out_ready;
		op          = OP_NONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					op      = OP_LOAD;
					axis_d  = AXIS_PITCH;
					state_d = S_GMUL;
				end
			end
			S_GMUL: begin
				op      = OP_GMUL;
				state_d = S_GADD;
			end
			S_GADD: begin
				op = OP_GADD;
				if (axis_q == AXIS_YAW) begin
					state_d = S_CHECK;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_GMUL;
				end
			end
			S_CHECK: begin
				state_d = stat.corr ? S_SQX : S_DONE;
			end
			S_SQX: begin
				op      = OP_SQX;
				state_d = S_SQZ;
			end
			S_SQZ: begin
				op      = OP_SQZ;
				state_d = S_SQI;
			end
			S_SQI: begin
				op      = OP_SQI;
				step_d  = '0;
				state_d = S_SQS;
			end
			S_SQS: begin
				op     = OP_SQS;
				step_d = step_q + 1'b1;
				if (step_q == STEP_W'(SQRT_STEPS - 1)) begin
					axis_d  = AXIS_PITCH;
					state_d = S_CINIT;
				end
			end
			S_CINIT: begin
				op      = OP_CINIT;
				step_d  = '0;
				state_d = S_CSTEP;
			end
			S_CSTEP: begin
				op     = OP_CSTEP;
				step_d = step_q + 1'b1;
				if (step_q == STEP_W'(CORDIC_STEPS - 1)) begin
					state_d = S_BMA;
				end
			end
			S_BMA: begin
				op      = OP_BMA;
				state_d = S_BMB;
			end
			S_BMB: begin
				op      = OP_BMB;
				state_d = S_BSUM;
			end
			S_BSUM: begin
				op = OP_BSUM;
				if (axis_q == AXIS_YAW) begin
					state_d = S_DONE;
				end else begin
					axis_d  = axis_q + 2'd1;
					state_d = S_CINIT;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					op          = OP_OUT;
					out_valid_d = 1'b1;
					state_d     = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			axis_q      <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			axis_q      <= axis_d;
			step_q      <= step_d;
			out_valid_q <= out_valid_d;
		end
	end

	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_GMUL))
		else $error("accepted request did not start gyro pass");

	a_done_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && (!out_valid_q || out_ready)) |=> (out_valid_q && in_ready))
		else $error("finished request not presented");

	a_axis_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> (axis_q != 2'd3))
		else $error("axis index out of range");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |=> out_valid_q)
		else $error("pending result dropped");

endmodule

@@ rtl/core/iac_dp.sv @@
// datapath: gyro integration, magnitude window, isqrt, cordic and blend
`timescale 1ns / 1ps
module iac_dp
	import iac_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  in_t              in_data,
	input  cmd_t             cmd,
	input  logic [31:0]      gyro_gain,
	input  logic [CFG_W-1:0] magnitude_low,
	input  logic [CFG_W-1:0] magnitude_high,
	input  logic [CFG_W-1:0] blend_weight,
	output stat_t            stat,
	output out_t             out_data
);

	in_t                      smp_q;
	out_t                     out_q;
	logic signed [ANG_W-1:0]  ang_q [3];
	logic signed [PROD_W-1:0] prod_q, pa_q, prod, acc_sum;
	logic signed [MUL_W-1:0]  ma, mb;
	logic [SQ_W-1:0]          sq_v_q, sq_res_q, sq_bit_q, trial;
	logic signed [CW-1:0]     cx_q, cy_q, x_s, y_s, dx, dy;
	logic signed [ANG_W-1:0]  cz_q, ang_sel;
	logic                     czero_q;
	logic signed [RAW_W-1:0]  x_raw, y_raw;
	logic signed [SAMPLE_BITS:0] ax_e, ay_e, az_e;
	logic [SAMPLE_BITS:0]     abs_x, abs_y, abs_z;
	logic [MAG_W-1:0]         mag;
	logic                     corr;
	logic [CFG_W-1:0]         w, wc;
	logic signed [SAMPLE_BITS-1:0] g_sel;

	assign ax_e  = {smp_q.accel_x[SAMPLE_BITS-1], smp_q.accel_x};
	assign ay_e  = {smp_q.accel_y[SAMPLE_BITS-1], smp_q.accel_y};
	assign az_e  = {smp_q.accel_z[SAMPLE_BITS-1], smp_q.accel_z};
	assign abs_x = ax_e[SAMPLE_BITS] ? -ax_e : ax_e;
	assign abs_y = ay_e[SAMPLE_BITS] ? -ay_e : ay_e;
	assign abs_z = az_e[SAMPLE_BITS] ? -az_e : az_e;
	assign mag   = MAG_W'(abs_x) + MAG_W'(abs_y) + MAG_W'(abs_z);
	assign corr  = (mag > MAG_W'(magnitude_low)) && (mag < MAG_W'(magnitude_high));
	assign stat  = '{corr: corr};

	assign w  = (blend_weight > CFG_W'(Q16_ONE)) ? CFG_W'(Q16_ONE) : blend_weight;
	assign wc = CFG_W'(Q16_ONE) - w;

	always_comb begin
		case (cmd.axis)
			AXIS_PITCH: begin
				ang_sel = ang_q[0];
				g_sel   = smp_q.gyro_x;
				y_raw   = RAW_W'(smp_q.accel_y);
				x_raw   = RAW_W'(smp_q.accel_z);
			end
			AXIS_ROLL: begin
				ang_sel = ang_q[1];
				g_sel   = smp_q.gyro_y;
				y_raw   = RAW_W'(smp_q.accel_x);
				x_raw   = RAW_W'(smp_q.accel_z);
			end
			default: begin
				ang_sel = ang_q[2];
				g_sel   = smp_q.gyro_z;
				y_raw   = RAW_W'(smp_q.accel_z) <<< 7;
				x_raw   = RAW_W'(sq_res_q);
			end
		endcase
	end

	assign y_s = CW'(y_raw) <<< 16;
	assign x_s = CW'(x_raw) <<< 16;
	assign dx  = cy_q >>> cmd.step;
	assign dy  = cx_q >>> cmd.step;

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.op)
			OP_GMUL: begin
				ma = MUL_W'(g_sel);
				mb = MUL_W'(gyro_gain);
			end
			OP_SQX: begin
				ma = MUL_W'(smp_q.accel_x);
				mb = MUL_W'(smp_q.accel_x);
			end
			OP_SQZ: begin
				ma = MUL_W'(smp_q.accel_z);
				mb = MUL_W'(smp_q.accel_z);
			end
			OP_BMA: begin
				ma = MUL_W'(ang_sel);
				mb = MUL_W'(w);
			end
			OP_BMB: begin
				ma = MUL_W'(cz_q);
				mb = MUL_W'(wc);
			end
			default: begin
				ma = '0;
			end
		endcase
	end

	assign prod    = ma * mb;
	assign trial   = sq_res_q + sq_bit_q;
	assign acc_sum = (cmd.op == OP_GADD)
		? PROD_W'(ang_sel) + ((prod_q + RND_HALF) >>> 16)
		: (pa_q + prod_q + RND_HALF) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q[0] <= '0;
			ang_q[1] <= '0;
			ang_q[2] <= '0;
		end else if (cmd.op == OP_GADD || cmd.op == OP_BSUM) begin
			case (cmd.axis)
				AXIS_PITCH: ang_q[0] <= sat32(acc_sum);
				AXIS_ROLL:  ang_q[1] <= sat32(acc_sum);
				default:    ang_q[2] <= sat32(acc_sum);
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				smp_q <= in_data;
			end
			OP_GMUL, OP_SQX, OP_BMA: begin
				prod_q <= prod;
			end
			OP_SQZ: begin
				sq_v_q <= SQ_W'(prod_q) << 14;
				prod_q <= prod;
			end
			OP_SQI: begin
				sq_v_q   <= sq_v_q + (SQ_W'(prod_q) << 14);
				sq_res_q <= '0;
				sq_bit_q <= SQ_W'(1) << SQRT_TOP;
			end
			OP_SQS: begin
				if (sq_v_q >= trial) begin
					sq_v_q   <= sq_v_q - trial;
					sq_res_q <= (sq_res_q >> 1) + sq_bit_q;
				end else begin
					sq_res_q <= sq_res_q >> 1;
				end
				sq_bit_q <= sq_bit_q >> 2;
			end
			OP_CINIT: begin
				czero_q <= (y_raw == '0) && (x_raw == '0);
				if (x_s[CW-1]) begin
					if (!y_s[CW-1]) begin
						cx_q <= y_s;
						cy_q <= -x_s;
						cz_q <= Z_90;
					end else begin
						cx_q <= -y_s;
						cy_q <= x_s;
						cz_q <= -Z_90;
					end
				end else begin
					cx_q <= x_s;
					cy_q <= y_s;
					cz_q <= '0;
				end
			end
			OP_CSTEP: begin
				if (!czero_q) begin
					if (!cy_q[CW-1] && cy_q != '0) begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + ATAN_TAB[cmd.step];
					end else begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - ATAN_TAB[cmd.step];
					end
				end
			end
			OP_BMB: begin
				pa_q   <= prod_q;
				prod_q <= prod;
			end
			OP_OUT: begin
				out_q <= '{pitch_out: ang_q[0], roll_out: ang_q[1],
					yaw_out: ang_q[2], corrected: corr};
			end
			default: begin
			end
		endcase
	end

	assign out_data = out_q;

endmodule
